>>> design/tsc_pkg.sv
// Shared constants, widths and control types of the Taylor sine/cosine block.
`timescale 1ns / 1ps
`default_nettype none
package tsc_pkg;

	// Ports
	localparam int ANGLE_W = 32;                      // Q8.24 angle
	localparam int VALUE_W = 32;                      // Q2.30 result

	// Range reduction: angle magnitude in Q.48, restoring steps against 2*pi
	localparam int RED_W      = 56;
	localparam int RED_FRAC   = 24;                   // Q8.24 -> Q.48
	localparam int RED_STEPS  = 5;                    // quotient never exceeds 20
	localparam int RED_SEL_W  = $clog2(RED_STEPS);
	localparam logic [RED_W-1:0] TWO_PI_Q48 = 56'h6_487E_D511_0B46;
	localparam int X_SHIFT    = 8;                    // Q.48 -> Q.40

	// Shared multiplier: two halves per operand, four partial products
	localparam int MUL_W      = RED_W - X_SHIFT;      // 48
	localparam int HALF_W     = MUL_W / 2;            // 24
	localparam int FULL_W     = 2 * MUL_W;            // 96
	localparam int MUL_PARTS  = 4;
	localparam int MUL_CNT_W  = 3;
	localparam int MUL_SHIFT  = 40;                   // Q.40 product rescale
	localparam int PROD_W     = 56;                   // kept product bits

	// Series
	localparam int TERM_W     = 48;
	localparam int X2_W       = 46;
	localparam int SUM_W      = 52;
	localparam int OUT_SHIFT  = 10;                   // Q.40 -> Q2.30
	localparam logic [TERM_W-1:0] ONE_Q40 = 48'h100_0000_0000;

	// Radix-16 divider
	localparam int RADIX_W    = 4;
	localparam int RADIX      = 1 << RADIX_W;
	localparam int DIGITS     = PROD_W / RADIX_W;     // 14
	localparam int DIG_CNT_W  = $clog2(DIGITS);

	typedef struct packed {
		logic                 load;
		logic                 red_step;
		logic [RED_SEL_W-1:0] red_sel;
		logic                 sq_start;
		logic                 init_term;
		logic                 add_term;
		logic                 mul_start;
		logic                 div_start;
		logic                 take_quot;
		logic                 sub_term;
		logic                 finish;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic t_lt_limit;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> design/tsc_if.sv
// Request and response channel interfaces of the Taylor sine/cosine block.
`timescale 1ns / 1ps
`default_nettype none
interface tsc_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic signed [tsc_pkg::ANGLE_W-1:0] angle;

	modport source (output valid, output req_type, output angle, input ready);
	modport sink   (input valid, input req_type, input angle, output ready);
endinterface

interface tsc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [tsc_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

>>> design/tsc_mul.sv
// Shared 48x48 multiplier built from four registered 24x24 partial products.
`timescale 1ns / 1ps
`default_nettype none
module tsc_mul (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [tsc_pkg::MUL_W-1:0]   a,
	input  wire  [tsc_pkg::MUL_W-1:0]   b,
	output logic                        done,
	output logic [tsc_pkg::PROD_W-1:0]  prod
);
	import tsc_pkg::*;

	logic                 busy_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 pp_vld_q;
	logic                 done_q;
	logic [MUL_W-1:0]     a_q;
	logic [MUL_W-1:0]     b_q;
	logic [MUL_W-1:0]     pp_q;
	logic [1:0]           sh_q;
	logic [FULL_W-1:0]    acc_q;

	logic [HALF_W-1:0]    a_half;
	logic [HALF_W-1:0]    b_half;
	logic [1:0]           sh_d;
	logic [FULL_W-1:0]    pp_shifted;
	logic                 issue;

	assign issue = (cnt_q != MUL_CNT_W'(MUL_PARTS));

	always_comb begin
		a_half = a_q[HALF_W-1:0];
		b_half = b_q[HALF_W-1:0];
		sh_d   = 2'd0;
		case (cnt_q[1:0])
			2'd0: begin
				sh_d = 2'd0;
			end
			2'd1: begin
				b_half = b_q[MUL_W-1:HALF_W];
				sh_d   = 2'd1;
			end
			2'd2: begin
				a_half = a_q[MUL_W-1:HALF_W];
				sh_d   = 2'd1;
			end
			2'd3: begin
				a_half = a_q[MUL_W-1:HALF_W];
				b_half = b_q[MUL_W-1:HALF_W];
				sh_d   = 2'd2;
			end
			default: begin
				sh_d = 2'd0;
			end
		endcase
	end

	always_comb begin
		case (sh_q)
			2'd0:    pp_shifted = FULL_W'(pp_q);
			2'd1:    pp_shifted = FULL_W'(pp_q) << HALF_W;
			2'd2:    pp_shifted = FULL_W'(pp_q) << (2 * HALF_W);
			default: pp_shifted = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			pp_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				pp_vld_q <= 1'b0;
			end else if (busy_q) begin
				if (issue) begin
					cnt_q    <= cnt_q + MUL_CNT_W'(1);
					pp_vld_q <= 1'b1;
				end else begin
					pp_vld_q <= 1'b0;
					// last partial product lands this cycle
					if (pp_vld_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (issue) begin
				pp_q <= a_half * b_half;
				sh_q <= sh_d;
			end
			if (pp_vld_q) begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q[MUL_SHIFT +: PROD_W];

endmodule
`default_nettype wire

>>> design/tsc_div.sv
// Radix-16 restoring divider of the scaled product by the term denominator.
`timescale 1ns / 1ps
`default_nettype none
module tsc_div #(
	parameter int D_W = 13
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [tsc_pkg::PROD_W-1:0]  dividend,
	input  wire  [D_W-1:0]              divisor,
	output logic                        done,
	output logic [tsc_pkg::PROD_W-1:0]  quot
);
	import tsc_pkg::*;

	localparam int DM_W = D_W + RADIX_W;

	logic                 busy_q;
	logic [DIG_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [PROD_W-1:0]    num_q;
	logic [PROD_W-1:0]    quo_q;
	logic [D_W-1:0]       r_q;
	logic [DM_W-1:0]      mult_q [1:RADIX-1];

	logic [DM_W-1:0]      rr;
	logic [DM_W-1:0]      sel;
	logic [DM_W-1:0]      r_next;
	logic [RADIX_W-1:0]   dig;

	// pick the largest multiple of the divisor that fits
	always_comb begin
		rr  = {r_q, num_q[PROD_W-1 -: RADIX_W]};
		dig = '0;
		sel = '0;
		for (int k = 1; k < RADIX; k++) begin
			if (rr >= mult_q[k]) begin
				dig = RADIX_W'(k);
				sel = mult_q[k];
			end
		end
		r_next = rr - sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIG_CNT_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + DIG_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			r_q   <= '0;
			for (int k = 1; k < RADIX; k++) begin
				mult_q[k] <= DM_W'(divisor) * DM_W'(k);
			end
		end else if (busy_q) begin
			num_q <= num_q << RADIX_W;
			r_q   <= r_next[D_W-1:0];
			quo_q <= {quo_q[PROD_W-RADIX_W-1:0], dig};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

>>> design/tsc_dp.sv
// Datapath: range reduction, series registers, accumulator and result saturation.
`timescale 1ns / 1ps
`default_nettype none
module tsc_dp #(
	parameter int ITERATION_LIMIT = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  tsc_pkg::dp_cmd_t                   cmd,
	output tsc_pkg::dp_sts_t                   sts,
	input  wire                                req_type,
	input  wire  signed [tsc_pkg::ANGLE_W-1:0] angle,
	output logic signed [tsc_pkg::VALUE_W-1:0] value
);
	import tsc_pkg::*;

	localparam int T_W  = $clog2(ITERATION_LIMIT + 4);
	localparam int D_W  = $clog2((ITERATION_LIMIT + 2) * (ITERATION_LIMIT + 3) + 1);
	localparam int SH_W = SUM_W - OUT_SHIFT;

	function automatic logic [D_W-1:0] pair_prod(input logic [T_W-1:0] n);
		logic [D_W-1:0] np1;
		np1 = D_W'(n) + D_W'(1);
		return np1 * (np1 + D_W'(1));
	endfunction

	function automatic logic [T_W-1:0] req_type_init(input logic sine);
		return sine ? T_W'(1) : T_W'(0);
	endfunction

	logic                     is_sine_q;
	logic                     neg_q;
	logic [RED_W-1:0]         rem_q;
	logic [X2_W-1:0]          x2_q;
	logic [TERM_W-1:0]        term_q;
	logic [T_W-1:0]           t_q;
	logic [D_W-1:0]           d_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [VALUE_W-1:0] value_q;

	logic [ANGLE_W-1:0]       mag;
	logic [RED_W-1:0]         red_sub;
	logic [MUL_W-1:0]         x;
	logic [MUL_W-1:0]         mul_a;
	logic [MUL_W-1:0]         mul_b;
	logic                     mul_start;
	logic                     mul_done;
	logic [PROD_W-1:0]        mul_prod;
	logic                     div_done;
	logic [PROD_W-1:0]        div_quot;
	logic [TERM_W-1:0]        quot_term;
	logic [T_W-1:0]           t_init;
	logic [T_W-1:0]           t_adv;
	logic signed [SUM_W-1:0]  sum_fin;
	logic signed [SH_W-1:0]   sum_sh;
	logic signed [VALUE_W-1:0] sat;

	assign mag       = angle[ANGLE_W-1] ? (ANGLE_W'(0) - angle) : angle;
	assign red_sub   = TWO_PI_Q48 << cmd.red_sel;
	assign x         = rem_q[RED_W-1:X_SHIFT];
	assign mul_start = cmd.sq_start | cmd.mul_start;
	assign mul_a     = cmd.sq_start ? x : term_q;
	assign mul_b     = cmd.sq_start ? x : MUL_W'(x2_q);
	assign quot_term = div_quot[TERM_W-1:0];
	assign t_init    = req_type_init(is_sine_q);
	assign t_adv     = t_q + T_W'(2);

	tsc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	tsc_div #(
		.D_W (D_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mul_prod),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	// sine of a negative angle flips sign; floor shift to Q2.30, then clamp
	always_comb begin
		sum_fin = (is_sine_q && neg_q) ? -sum_q : sum_q;
		sum_sh  = sum_fin[SUM_W-1:OUT_SHIFT];
		if (sum_sh[SH_W-1:VALUE_W-1] == {(SH_W-VALUE_W+1){sum_sh[SH_W-1]}}) begin
			sat = sum_sh[VALUE_W-1:0];
		end else if (sum_sh[SH_W-1]) begin
			sat = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(VALUE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_sine_q <= req_type;
			neg_q     <= angle[ANGLE_W-1];
			rem_q     <= {mag, {RED_FRAC{1'b0}}};
		end
		if (cmd.red_step && (rem_q >= red_sub)) begin
			rem_q <= rem_q - red_sub;
		end
		if (cmd.init_term) begin
			x2_q   <= mul_prod[X2_W-1:0];
			term_q <= is_sine_q ? TERM_W'(x) : ONE_Q40;
			t_q    <= t_init;
			d_q    <= pair_prod(t_init);
			sum_q  <= '0;
		end
		if (cmd.add_term) begin
			sum_q <= sum_q + $signed({{(SUM_W-TERM_W){1'b0}}, term_q});
		end
		if (cmd.take_quot) begin
			term_q <= quot_term;
			t_q    <= t_adv;
			d_q    <= pair_prod(t_adv);
			if (cmd.sub_term) begin
				sum_q <= sum_q - $signed({{(SUM_W-TERM_W){1'b0}}, quot_term});
			end
		end
		if (cmd.finish) begin
			value_q <= sat;
		end
	end

	assign sts.mul_done   = mul_done;
	assign sts.div_done   = div_done;
	assign sts.t_lt_limit = (t_q < T_W'(ITERATION_LIMIT));
	assign value          = value_q;

endmodule
`default_nettype wire

>>> design/tsc_ctrl.sv
// Controller state machine that sequences reduction, term updates and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module tsc_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire                     out_ready,
	output tsc_pkg::dp_cmd_t        cmd,
	input  tsc_pkg::dp_sts_t        sts
);
	import tsc_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED  = 4'd1;
	localparam logic [3:0] S_SQS  = 4'd2;
	localparam logic [3:0] S_SQ   = 4'd3;
	localparam logic [3:0] S_TOP  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_MULS = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]           state_q;
	logic [3:0]           state_d;
	logic [RED_SEL_W-1:0] cnt_q;
	logic                 phase_q;
	logic                 out_vld_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RED;
				end
			end
			S_RED: begin
				cmd.red_step = 1'b1;
				cmd.red_sel  = cnt_q;
				if (cnt_q == '0) begin
					state_d = S_SQS;
				end
			end
			S_SQS: begin
				cmd.sq_start = 1'b1;
				state_d      = S_SQ;
			end
			S_SQ: begin
				if (sts.mul_done) begin
					cmd.init_term = 1'b1;
					state_d       = S_TOP;
				end
			end
			S_TOP: begin
				if (sts.t_lt_limit) begin
					cmd.add_term  = 1'b1;
					cmd.mul_start = 1'b1;
					state_d       = S_MUL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MUL: begin
				if (sts.mul_done) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					// first update of a round is subtracted, second waits for the next add
					cmd.take_quot = 1'b1;
					cmd.sub_term  = !phase_q;
					state_d       = phase_q ? S_TOP : S_MULS;
				end
			end
			S_MULS: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MUL;
			end
			S_FIN: begin
				if (!out_vld_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			phase_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= RED_SEL_W'(RED_STEPS - 1);
			end else if (cmd.red_step) begin
				cnt_q <= cnt_q - RED_SEL_W'(1);
			end
			if (cmd.init_term) begin
				phase_q <= 1'b0;
			end else if (cmd.take_quot) begin
				phase_q <= !phase_q;
			end
			if (cmd.finish) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

`ifndef SYNTHESIS
	a_accept_starts_reduction: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_RED)
		else $error("accepted word did not start range reduction");

	a_mul_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == S_SQ || state_q == S_MUL)
		else $error("multiplier finished while controller was not waiting for it");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIV)
		else $error("divider finished while controller was not waiting for it");

	a_single_unit_start: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sq_start, cmd.mul_start, cmd.div_start, cmd.take_quot}))
		else $error("more than one unit command issued in a cycle");
`endif

endmodule
`default_nettype wire

>>> design/taylor_sine_cosine.sv
// Top level of the Taylor-series sine/cosine unit.
`timescale 1ns / 1ps
`default_nettype none
// Computes cosine (req_type 0) or sine (req_type 1) of a Q8.24 radian angle and
// returns one saturated Q2.30 word per request. The angle magnitude is reduced
// modulo 2*pi by five restoring compare-subtract steps, squared, and the
// alternating Taylor series is then summed two terms per round while the term
// index stays below ITERATION_LIMIT. Each term update runs on one shared
// 48x48 multiplier (four 24x24 partial products) followed by a radix-16
// divider by (n+1)(n+2). Each round advances the term index by four, from
// t0 = 0 for cosine and 1 for sine. One item is in work at a time; a
// finished word waits in the output register while the next request is
// accepted.
module taylor_sine_cosine #(
	parameter int ITERATION_LIMIT = 32
) (
	input wire        clk,
	input wire        arst_n,
	tsc_req_if.sink   req,
	tsc_rsp_if.source rsp
);
	import tsc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	tsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tsc_dp #(
		.ITERATION_LIMIT (ITERATION_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_type (req.req_type),
		.angle    (req.angle),
		.value    (rsp.value)
	);

endmodule
`default_nettype wire
